// ----- src/itoa_pkg.sv -----
package itoa_pkg;

	typedef enum logic [2:0] {
		CMD_CHAR = 3'd0,
		CMD_SDEC = 3'd1,
		CMD_UDEC = 3'd2,
		CMD_HEXL = 3'd3,
		CMD_HEXU = 3'd4,
		CMD_PTR  = 3'd5,
		CMD_PCT  = 3'd6
	} cmd_t;

	typedef logic [3:0] upc_t;

	localparam upc_t PC_IDLE   = 4'd0;
	localparam upc_t PC_CHAR   = 4'd1;
	localparam upc_t PC_PCT    = 4'd2;
	localparam upc_t PC_SIGN   = 4'd3;
	localparam upc_t PC_MINUS  = 4'd4;
	localparam upc_t PC_DEC    = 4'd5;
	localparam upc_t PC_DABBLE = 4'd6;
	localparam upc_t PC_BCD    = 4'd7;
	localparam upc_t PC_DIGIT  = 4'd8;
	localparam upc_t PC_END    = 4'd9;
	localparam upc_t PC_HEX    = 4'd10;
	localparam upc_t PC_PTR0   = 4'd11;
	localparam upc_t PC_PTRX   = 4'd12;
	localparam upc_t PC_PTRLD  = 4'd13;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_NONE    = 8'h00;

	localparam int unsigned BCD_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_EMIT_LOW8,
		ACT_EMIT_CONST,
		ACT_LOAD_BIN,
		ACT_DABBLE,
		ACT_LOAD_BCD,
		ACT_LOAD_HEX32,
		ACT_LOAD_PTR,
		ACT_DIGIT
	} act_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NOTNEG,
		JC_CNT_MORE,
		JC_DIG_MORE
	} jc_t;

	typedef struct packed {
		act_t       act;
		jc_t        jc;
		upc_t       target;
		logic [7:0] chr;
		logic       last;
	} uword_t;

	function automatic uword_t mk(act_t act, jc_t jc, upc_t target, logic [7:0] chr,
		logic last);
		uword_t w;
		w.act    = act;
		w.jc     = jc;
		w.target = target;
		w.chr    = chr;
		w.last   = last;
		return w;
	endfunction

	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		case (pc)
			PC_CHAR:   w = mk(ACT_EMIT_LOW8,  JC_ALWAYS,   PC_IDLE,   CH_NONE,    1'b1);
			PC_PCT:    w = mk(ACT_EMIT_CONST, JC_ALWAYS,   PC_IDLE,   CH_PERCENT, 1'b1);
			PC_SIGN:   w = mk(ACT_NOP,        JC_NOTNEG,   PC_DEC,    CH_NONE,    1'b0);
			PC_MINUS:  w = mk(ACT_EMIT_CONST, JC_NEXT,     PC_IDLE,   CH_MINUS,   1'b0);
			PC_DEC:    w = mk(ACT_LOAD_BIN,   JC_NEXT,     PC_IDLE,   CH_NONE,    1'b0);
			PC_DABBLE: w = mk(ACT_DABBLE,     JC_CNT_MORE, PC_DABBLE, CH_NONE,    1'b0);
			PC_BCD:    w = mk(ACT_LOAD_BCD,   JC_ALWAYS,   PC_DIGIT,  CH_NONE,    1'b0);
			PC_DIGIT:  w = mk(ACT_DIGIT,      JC_DIG_MORE, PC_DIGIT,  CH_NONE,    1'b0);
			PC_END:    w = mk(ACT_NOP,        JC_ALWAYS,   PC_IDLE,   CH_NONE,    1'b0);
			PC_HEX:    w = mk(ACT_LOAD_HEX32, JC_ALWAYS,   PC_DIGIT,  CH_NONE,    1'b0);
			PC_PTR0:   w = mk(ACT_EMIT_CONST, JC_NEXT,     PC_IDLE,   CH_ZERO,    1'b0);
			PC_PTRX:   w = mk(ACT_EMIT_CONST, JC_NEXT,     PC_IDLE,   CH_X,       1'b0);
			PC_PTRLD:  w = mk(ACT_LOAD_PTR,   JC_ALWAYS,   PC_DIGIT,  CH_NONE,    1'b0);
			default:   w = mk(ACT_NOP,        JC_ALWAYS,   PC_IDLE,   CH_NONE,    1'b0);
		endcase
		return w;
	endfunction

	function automatic upc_t entry(logic [2:0] cmd);
		upc_t pc;
		case (cmd)
			CMD_CHAR: pc = PC_CHAR;
			CMD_SDEC: pc = PC_SIGN;
			CMD_UDEC: pc = PC_DEC;
			CMD_HEXL: pc = PC_HEX;
			CMD_HEXU: pc = PC_HEX;
			CMD_PTR:  pc = PC_PTR0;
			CMD_PCT:  pc = PC_PCT;
			default:  pc = PC_IDLE;
		endcase
		return pc;
	endfunction

endpackage

// ----- src/integer_to_ascii_formatter.sv -----
// Formats one request (a command and a 64-bit argument) into ASCII characters, most
// significant first, with tlast on the final one; the unused command code is
// consumed and produces nothing. A short microprogram drives the datapath and one
// request is handled at a time. Decimal runs a binary-to-BCD loop that shifts in the
// low 32 argument bits, one bit per cycle, before the ten digit steps; hex uses the
// low 32 bits as eight digits and a pointer all 64 bits as sixteen. Leading zeros
// are stepped over without output. Output stalls only hold the sequencer.
module integer_to_ascii_formatter
	import itoa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // command [2:0], value [66:3], zero [71:67]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // character [7:0]
	output logic        m_tlast   // last
);

	upc_t              pc_q;
	logic [2:0]        cmd_q;
	logic [63:0]       val_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [5:0]        cnt_q;
	logic              seen_q;
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;

	uword_t            uw;
	logic              busy;
	logic              emits;
	logic              out_free;
	logic              go;
	logic              neg;
	logic              take;
	upc_t              pc_next;
	logic [3:0]        dig;
	logic              skip;
	logic [7:0]        dig_char;
	logic [BCD_W-1:0]  bcd_adj;
	logic [31:0]       bin_load;

	assign s_tready = (pc_q == PC_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		uw       = ucode(pc_q);
		busy     = (pc_q != PC_IDLE);
		emits    = (uw.act == ACT_EMIT_LOW8) || (uw.act == ACT_EMIT_CONST) ||
			(uw.act == ACT_DIGIT);
		out_free = !out_valid_q || m_tready;
		go       = busy && (!emits || out_free);
		neg      = (cmd_q == CMD_SDEC) && val_q[31];
		bin_load = neg ? (32'd0 - val_q[31:0]) : val_q[31:0];

		case (uw.jc)
			JC_ALWAYS:   take = 1'b1;
			JC_NOTNEG:   take = !neg;
			JC_CNT_MORE: take = (cnt_q != 6'd1);
			JC_DIG_MORE: take = (cnt_q != 6'd1);
			default:     take = 1'b0;
		endcase
		pc_next = take ? uw.target : pc_q + 4'd1;

		dig  = val_q[63:60];
		skip = (dig == 4'd0) && !seen_q && (cnt_q != 6'd1);
		if (dig < 4'd10) begin
			dig_char = CH_ZERO + {4'd0, dig};
		end else if (cmd_q == CMD_HEXU) begin
			dig_char = CH_UPPER_A + {4'd0, dig} - 8'd10;
		end else begin
			dig_char = CH_LOWER_A + {4'd0, dig} - 8'd10;
		end

		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (go && emits && !(uw.act == ACT_DIGIT && skip)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy) begin
				if (s_tvalid) begin
					pc_q <= entry(s_tdata[2:0]);
				end
			end else if (go) begin
				pc_q <= pc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy) begin
			if (s_tvalid) begin
				cmd_q <= s_tdata[2:0];
				val_q <= s_tdata[66:3];
			end
		end else if (go) begin
			case (uw.act)
				ACT_EMIT_LOW8: begin
					out_char_q <= val_q[7:0];
					out_last_q <= uw.last;
				end
				ACT_EMIT_CONST: begin
					out_char_q <= uw.chr;
					out_last_q <= uw.last;
				end
				ACT_LOAD_BIN: begin
					val_q[31:0] <= bin_load;
					bcd_q       <= '0;
					cnt_q       <= 6'd32;
				end
				ACT_DABBLE: begin
					bcd_q       <= {bcd_adj[BCD_W-2:0], val_q[31]};
					val_q[31:0] <= {val_q[30:0], 1'b0};
					cnt_q       <= cnt_q - 6'd1;
				end
				ACT_LOAD_BCD: begin
					val_q  <= {bcd_q, {(64 - BCD_W){1'b0}}};
					cnt_q  <= 6'(BCD_DIGITS);
					seen_q <= 1'b0;
				end
				ACT_LOAD_HEX32: begin
					val_q  <= {val_q[31:0], 32'd0};
					cnt_q  <= 6'd8;
					seen_q <= 1'b0;
				end
				ACT_LOAD_PTR: begin
					cnt_q  <= 6'd16;
					seen_q <= 1'b0;
				end
				ACT_DIGIT: begin
					val_q <= {val_q[59:0], 4'd0};
					cnt_q <= cnt_q - 6'd1;
					if (!skip) begin
						seen_q     <= 1'b1;
						out_char_q <= dig_char;
						out_last_q <= (cnt_q == 6'd1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
